[src/tfc_pkg.sv]
// tfc_pkg: shared types, constants and microcode for the timecode frame counter
// payload structs for the request/result channels, rate tables, control-store program
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tfc_pkg;

    // request and result payloads
    typedef struct packed {
        logic [1:0] action;
        logic [1:0] hour_tens;
        logic [3:0] hour_units;
        logic [2:0] minute_tens;
        logic [3:0] minute_units;
        logic [2:0] second_tens;
        logic [3:0] second_units;
        logic [1:0] frame_tens;
        logic [3:0] frame_units;
    } tfc_in_t;

    typedef struct packed {
        logic [22:0] count_now;
        logic [5:0]  hours_out;
        logic [5:0]  minutes_out;
        logic [5:0]  seconds_out;
        logic [4:0]  frames_out;
    } tfc_out_t;

    localparam int COUNT_W = 23;
    localparam int ACC_W   = 18;

    // action codes
    localparam logic [1:0] ACT_JAM     = 2'd0;
    localparam logic [1:0] ACT_ADVANCE = 2'd1;
    localparam logic [1:0] ACT_CLEAR   = 2'd2;

    // rate modes
    localparam logic [2:0] MODE_23_98 = 3'd0;
    localparam logic [2:0] MODE_24    = 3'd1;
    localparam logic [2:0] MODE_25    = 3'd2;
    localparam logic [2:0] MODE_DROP  = 3'd4;

    // configuration port
    localparam int         APB_ADDR_W    = 3;
    localparam int         APB_DATA_W    = 32;
    localparam logic       REG_RATE_MODE = 1'b0;

    localparam logic [5:0] SEC_PER_MIN    = 6'd60;
    localparam logic [4:0] DROP_LAST_FR   = 5'd29;
    localparam logic [5:0] LAST_SECOND    = 6'd59;

    // shared divider: dividend width, bits retired per cycle, number of divider steps
    localparam int DIV_W     = 24;
    localparam int DIV_RADIX = 3;
    localparam int DIV_STEPS = DIV_W / DIV_RADIX;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    function automatic logic [4:0] nominal_rate(input logic [2:0] mode);
        logic [4:0] r;
        unique case (mode)
            MODE_23_98, MODE_24: r = 5'd24;
            MODE_25:             r = 5'd25;
            default:             r = 5'd30;
        endcase
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] day_limit(input logic [2:0] mode);
        logic [COUNT_W-1:0] d;
        unique case (mode)
            MODE_23_98, MODE_24: d = 23'd2073600;
            MODE_25:             d = 23'd2160000;
            default:             d = 23'd2592000;
        endcase
        return d;
    endfunction

    // tens digit times ten plus units nibble
    function automatic logic [6:0] two_digits(input logic [2:0] tens, input logic [3:0] units);
        return 7'(tens) * 7'd10 + 7'(units);
    endfunction

    // minutes whose end is not skipped in drop frame
    function automatic logic tenth_minute_end(input logic [5:0] minute);
        logic hit;
        case (minute) inside
            6'd9, 6'd19, 6'd29, 6'd39, 6'd49, 6'd59: hit = 1'b1;
            default:                                   hit = 1'b0;
        endcase
        return hit;
    endfunction

    // microcode
    typedef enum logic [3:0] {
        OP_JAM_HM,
        OP_JAM_S,
        OP_JAM_F,
        OP_INC,
        OP_CLR,
        OP_DIV_RATE,
        OP_DIV_STEP,
        OP_SAVE_FR,
        OP_SAVE_SC,
        OP_SAVE_MN,
        OP_SKIP,
        OP_DONE
    } op_t;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_DIV_MORE,
        COND_SKIP,
        COND_OUT_FULL
    } cond_t;

    localparam int UPC_W = 4;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } ucode_t;

    localparam logic [UPC_W-1:0] UA_JAM   = 4'd0;
    localparam logic [UPC_W-1:0] UA_JAM_S = 4'd1;
    localparam logic [UPC_W-1:0] UA_JAM_F = 4'd2;
    localparam logic [UPC_W-1:0] UA_ADV   = 4'd3;
    localparam logic [UPC_W-1:0] UA_CLR   = 4'd4;
    localparam logic [UPC_W-1:0] UA_BRK   = 4'd5;
    localparam logic [UPC_W-1:0] UA_DIV1  = 4'd6;
    localparam logic [UPC_W-1:0] UA_SAV1  = 4'd7;
    localparam logic [UPC_W-1:0] UA_DIV2  = 4'd8;
    localparam logic [UPC_W-1:0] UA_SAV2  = 4'd9;
    localparam logic [UPC_W-1:0] UA_DIV3  = 4'd10;
    localparam logic [UPC_W-1:0] UA_SAV3  = 4'd11;
    localparam logic [UPC_W-1:0] UA_SKIP  = 4'd12;
    localparam logic [UPC_W-1:0] UA_DONE  = 4'd13;

    function automatic logic [UPC_W-1:0] entry_addr(input logic [1:0] action);
        logic [UPC_W-1:0] a;
        unique case (action)
            ACT_JAM:     a = UA_JAM;
            ACT_ADVANCE: a = UA_ADV;
            ACT_CLEAR:   a = UA_CLR;
            default:     a = UA_BRK;
        endcase
        return a;
    endfunction

    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
        ucode_t w;
        unique case (addr)
            UA_JAM:   w = '{op: OP_JAM_HM,   cond: COND_NONE,     target: UA_JAM};
            UA_JAM_S: w = '{op: OP_JAM_S,    cond: COND_NONE,     target: UA_JAM};
            UA_JAM_F: w = '{op: OP_JAM_F,    cond: COND_ALWAYS,   target: UA_BRK};
            UA_ADV:   w = '{op: OP_INC,      cond: COND_ALWAYS,   target: UA_BRK};
            UA_CLR:   w = '{op: OP_CLR,      cond: COND_NONE,     target: UA_JAM};
            UA_BRK:   w = '{op: OP_DIV_RATE, cond: COND_NONE,     target: UA_JAM};
            UA_DIV1:  w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE, target: UA_DIV1};
            UA_SAV1:  w = '{op: OP_SAVE_FR,  cond: COND_NONE,     target: UA_JAM};
            UA_DIV2:  w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE, target: UA_DIV2};
            UA_SAV2:  w = '{op: OP_SAVE_SC,  cond: COND_NONE,     target: UA_JAM};
            UA_DIV3:  w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE, target: UA_DIV3};
            UA_SAV3:  w = '{op: OP_SAVE_MN,  cond: COND_NONE,     target: UA_JAM};
            UA_SKIP:  w = '{op: OP_SKIP,     cond: COND_SKIP,     target: UA_BRK};
            default:  w = '{op: OP_DONE,     cond: COND_OUT_FULL, target: UA_DONE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[src/tfc_stream_if.sv]
// tfc_stream_if: valid/ready channel carrying one payload per request
// payload type is set per instance, normally from tfc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface tfc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[src/timecode_frame_counter_top.sv]
// timecode_frame_counter_top: microcoded timecode frame counter with apb rate register
// depends on tfc_pkg and tfc_stream_if
// timing: each request is run by a 14-word control program; a shared restoring divider
// retires 3 quotient bits per cycle and runs three times (by rate, by 60, by 60), and an advance
// that takes a drop-frame skip reruns the divisions. one request at a time; the next is taken
// as soon as the result is in the output register, even if not yet taken.
// jam loads the count from digit nibbles, advance adds a frame with day wrap and drop-frame
// skip (mode 4), clear zeroes it; every request returns the count and its breakdown.
`timescale 1ns / 1ps
`default_nettype none

module timecode_frame_counter_top
    import tfc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    tfc_stream_if.sink                 in_req,
    tfc_stream_if.source               out_res
);

    // control
    logic                 busy_reg, busy_next;
    logic [UPC_W-1:0]     upc_reg, upc_next;
    logic                 out_valid_reg, out_valid_next;
    logic [2:0]           rate_mode_reg, rate_mode_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    // datapath
    tfc_in_t              in_reg, in_next;
    logic                 adv_reg, adv_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [5:0]           div_rem_reg, div_rem_next;
    logic [DIV_W-1:0]     div_quo_reg, div_quo_next;
    logic [5:0]           div_den_reg, div_den_next;
    logic [4:0]           fr_reg, fr_next;
    logic [5:0]           sc_reg, sc_next;
    logic [5:0]           mn_reg, mn_next;
    logic [5:0]           hr_reg, hr_next;
    tfc_out_t             out_data_reg, out_data_next;

    ucode_t               uop;
    logic                 take;
    logic                 out_full;
    logic                 skip_hit;
    logic [4:0]           rate;
    logic [6:0]           jam_hr, jam_mn, jam_sc, jam_fr;
    logic [COUNT_W-1:0]   inc_count;
    logic [5:0]           step_rem;
    logic [DIV_W-1:0]     step_quo;
    logic [6:0]           trial;

    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_RATE_MODE) ? APB_DATA_W'(rate_mode_reg) : '0;
    assign in_req.ready  = !busy_reg;
    assign out_res.valid = out_valid_reg;
    assign out_res.payload = out_data_reg;

    assign uop      = ucode_rom(upc_reg);
    assign rate     = nominal_rate(rate_mode_reg);
    assign out_full = out_valid_reg && !out_res.ready;
    assign jam_hr   = two_digits({1'b0, in_reg.hour_tens}, in_reg.hour_units);
    assign jam_mn   = two_digits(in_reg.minute_tens, in_reg.minute_units);
    assign jam_sc   = two_digits(in_reg.second_tens, in_reg.second_units);
    assign jam_fr   = two_digits({1'b0, in_reg.frame_tens}, in_reg.frame_units);

    // drop frame: last frame of a minute that is not a tenth minute
    assign skip_hit = adv_reg && (rate_mode_reg == MODE_DROP) && (fr_reg == DROP_LAST_FR)
                      && (sc_reg == LAST_SECOND) && !tenth_minute_end(mn_reg);

    always_comb
    begin
        inc_count = count_reg + 1'b1;
        if (inc_count == day_limit(rate_mode_reg))
        begin
            inc_count = '0;
        end
    end

    // one divider cycle: DIV_RADIX restoring steps
    always_comb
    begin
        step_rem = div_rem_reg;
        step_quo = div_quo_reg;
        trial    = '0;
        for (int i = 0; i < DIV_RADIX; i++)
        begin
            trial    = {step_rem, step_quo[DIV_W-1]};
            step_quo = {step_quo[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, div_den_reg})
            begin
                trial       = trial - {1'b0, div_den_reg};
                step_quo[0] = 1'b1;
            end
            step_rem = trial[5:0];
        end
    end

    always_comb
    begin
        case (uop.cond)
            COND_NONE:     take = 1'b0;
            COND_ALWAYS:   take = 1'b1;
            COND_DIV_MORE: take = (div_cnt_reg != '0);
            COND_SKIP:     take = skip_hit;
            COND_OUT_FULL: take = out_full;
            default:       take = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        upc_next       = upc_reg;
        out_valid_next = out_valid_reg && !out_res.ready;
        rate_mode_next = rate_mode_reg;
        count_next     = count_reg;
        div_cnt_next   = div_cnt_reg;
        in_next        = in_reg;
        adv_next       = adv_reg;
        acc_next       = acc_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        div_den_next   = div_den_reg;
        fr_next        = fr_reg;
        sc_next        = sc_reg;
        mn_next        = mn_reg;
        hr_next        = hr_reg;
        out_data_next  = out_data_reg;

        if (psel && penable && pwrite && (paddr[2] == REG_RATE_MODE))
        begin
            rate_mode_next = pwdata[2:0];
        end

        if (!busy_reg)
        begin
            if (in_req.valid)
            begin
                busy_next = 1'b1;
                upc_next  = entry_addr(in_req.payload.action);
                in_next   = in_req.payload;
                adv_next  = (in_req.payload.action == ACT_ADVANCE);
            end
        end
        else
        begin
            upc_next = take ? uop.target : upc_reg + 1'b1;
            case (uop.op)
                OP_JAM_HM:
                begin
                    acc_next = ACC_W'(jam_hr) * ACC_W'(SEC_PER_MIN) + ACC_W'(jam_mn);
                end
                OP_JAM_S:
                begin
                    acc_next = acc_reg * ACC_W'(SEC_PER_MIN) + ACC_W'(jam_sc);
                end
                OP_JAM_F:
                begin
                    count_next = COUNT_W'(acc_reg) * COUNT_W'(rate) + COUNT_W'(jam_fr);
                end
                OP_INC:
                begin
                    count_next = inc_count;
                end
                OP_CLR:
                begin
                    count_next = '0;
                end
                OP_DIV_RATE:
                begin
                    div_rem_next = '0;
                    div_quo_next = DIV_W'(count_reg);
                    div_den_next = {1'b0, rate};
                    div_cnt_next = DIV_CNT_W'(DIV_STEPS - 1);
                end
                OP_DIV_STEP:
                begin
                    div_rem_next = step_rem;
                    div_quo_next = step_quo;
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
                OP_SAVE_FR, OP_SAVE_SC:
                begin
                    if (uop.op == OP_SAVE_FR)
                    begin
                        fr_next = div_rem_reg[4:0];
                    end
                    else
                    begin
                        sc_next = div_rem_reg;
                    end
                    div_rem_next = '0;
                    div_den_next = SEC_PER_MIN;
                    div_cnt_next = DIV_CNT_W'(DIV_STEPS - 1);
                end
                OP_SAVE_MN:
                begin
                    mn_next = div_rem_reg;
                    hr_next = div_quo_reg[5:0];
                end
                OP_SKIP:
                begin
                    if (skip_hit)
                    begin
                        count_next = count_reg + COUNT_W'(2);
                    end
                end
                OP_DONE:
                begin
                    if (!out_full)
                    begin
                        out_data_next  = '{count_now: count_reg, hours_out: hr_reg,
                                           minutes_out: mn_reg, seconds_out: sc_reg,
                                           frames_out: fr_reg};
                        out_valid_next = 1'b1;
                        busy_next      = 1'b0;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            upc_reg       <= UA_JAM;
            out_valid_reg <= 1'b0;
            rate_mode_reg <= MODE_23_98;
            count_reg     <= '0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            upc_reg       <= upc_next;
            out_valid_reg <= out_valid_next;
            rate_mode_reg <= rate_mode_next;
            count_reg     <= count_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg       <= in_next;
        adv_reg      <= adv_next;
        acc_reg      <= acc_next;
        div_rem_reg  <= div_rem_next;
        div_quo_reg  <= div_quo_next;
        div_den_reg  <= div_den_next;
        fr_reg       <= fr_next;
        sc_reg       <= sc_next;
        mn_reg       <= mn_next;
        hr_reg       <= hr_next;
        out_data_reg <= out_data_next;
    end

    // divider keeps the sequencer on its step until the last digit
    a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && uop.op == OP_DIV_STEP && div_cnt_reg != '0) |=> upc_reg == $past(upc_reg))
        else $error("sequencer left a division early");

    // count only moves while a request is in flight
    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |=> $stable(count_reg))
        else $error("count changed while idle");

    // a fresh result only appears as the program finishes
    a_result_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $fell(busy_reg))
        else $error("result raised outside the done step");

    // program counter stays inside the control store
    a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> upc_reg <= UA_DONE)
        else $error("program counter out of range");

    // a drop-frame skip adds exactly two counts
    a_skip_two: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && uop.op == OP_SKIP && skip_hit)
            |=> count_reg == $past(count_reg) + COUNT_W'(2))
        else $error("drop-frame skip did not add two");

endmodule

`default_nettype wire

[tb/tb_timecode_frame_counter_top.sv]
// tb_timecode_frame_counter_top: self-checking bench for the timecode frame counter
// predicts every result from its own count and rate model and checks results in order
// depends on tfc_pkg, tfc_stream_if and timecode_frame_counter_top
`timescale 1ns / 1ps

module tb_timecode_frame_counter_top;
    import tfc_pkg::*;

    localparam logic [1:0] ACT_IDLE    = 2'd3;
    localparam logic [2:0] MODE_29_97  = 3'd3;
    localparam logic [2:0] MODE_30     = 3'd5;
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;

    localparam logic [APB_ADDR_W-1:0] RATE_MODE_ADDR = APB_ADDR_W'(4 * REG_RATE_MODE);

    localparam int unsigned COUNT_MASK   = 32'h007F_FFFF;
    localparam int          STALL_LIMIT  = 4000;
    localparam int          SETTLE_WAIT  = 70;
    localparam int          PHASE_ITEMS  = 65;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    tfc_stream_if #(.payload_t(tfc_in_t))  req_if ();
    tfc_stream_if #(.payload_t(tfc_out_t)) res_if ();

    timecode_frame_counter_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_req  (req_if),
        .out_res (res_if)
    );

    // timecode model state
    logic [22:0] tc_count;
    logic [2:0]  tc_mode;
    tfc_out_t    expected_timecodes[$];

    bit          idle_on;
    int          error_count;
    int          requests_sent;
    int          results_seen;
    int          jams_sent;
    int          advances_sent;
    int          day_wraps;
    int          drop_skips;
    logic [7:0]  modes_seen;
    int          idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned fps_of(input logic [2:0] mode);
        int unsigned r;
        case (mode)
            MODE_23_98, MODE_24: r = 24;
            MODE_25:             r = 25;
            default:             r = 30;
        endcase
        return r;
    endfunction

    function automatic int unsigned day_frames(input logic [2:0] mode);
        int unsigned d;
        case (mode)
            MODE_23_98, MODE_24: d = 2073600;
            MODE_25:             d = 2160000;
            default:             d = 2592000;
        endcase
        return d;
    endfunction

    function automatic int unsigned digit_pair(input logic [2:0] tens, input logic [3:0] units);
        return int'(units) + int'(tens) * 10;
    endfunction

    // updates the model count and returns the breakdown for one request
    function automatic tfc_out_t predict_timecode(input tfc_in_t req);
        int unsigned rate;
        int unsigned hr;
        int unsigned mn;
        int unsigned sc;
        int unsigned fr;
        int unsigned c;
        int unsigned secs;
        tfc_out_t    res;
        rate = fps_of(tc_mode);
        case (req.action)
            ACT_JAM:
            begin
                hr = digit_pair({1'b0, req.hour_tens}, req.hour_units);
                mn = digit_pair(req.minute_tens, req.minute_units);
                sc = digit_pair(req.second_tens, req.second_units);
                fr = digit_pair({1'b0, req.frame_tens}, req.frame_units);
                tc_count = 23'((hr * 3600 * rate + mn * 60 * rate + sc * rate + fr) & COUNT_MASK);
            end
            ACT_ADVANCE:
            begin
                c = (int'(tc_count) + 1) & COUNT_MASK;
                if (c == day_frames(tc_mode))
                begin
                    c = 0;
                    day_wraps++;
                end
                // two counts dropped at minute ends, not at tenth minutes
                if (tc_mode == MODE_DROP && c % 30 == 29 && (c / 30) % 60 == 59 &&
                    ((c / 1800) % 60 + 1) % 10 != 0)
                begin
                    c = (c + 2) & COUNT_MASK;
                    drop_skips++;
                end
                tc_count = 23'(c);
            end
            ACT_CLEAR: tc_count = '0;
            default: ;
        endcase
        secs = int'(tc_count) / rate;
        res.count_now   = tc_count;
        res.hours_out   = 6'(secs / 3600);
        res.minutes_out = 6'((secs / 60) % 60);
        res.seconds_out = 6'(secs % 60);
        res.frames_out  = 5'(int'(tc_count) % rate);
        return res;
    endfunction

    function automatic tfc_in_t make_jam(input int hh, input int mm, input int ss, input int ff);
        tfc_in_t r;
        r.action       = ACT_JAM;
        r.hour_tens    = 2'(hh / 10);
        r.hour_units   = 4'(hh % 10);
        r.minute_tens  = 3'(mm / 10);
        r.minute_units = 4'(mm % 10);
        r.second_tens  = 3'(ss / 10);
        r.second_units = 4'(ss % 10);
        r.frame_tens   = 2'(ff / 10);
        r.frame_units  = 4'(ff % 10);
        return r;
    endfunction

    function automatic tfc_in_t make_request(input logic [1:0] act);
        tfc_in_t r;
        r        = tfc_in_t'($urandom);
        r.action = act;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        error_count++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic send_request(input tfc_in_t req);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid   = 1'b1;
        req_if.payload = req;
        do @(posedge clk); while (!req_if.ready);
        expected_timecodes.push_back(predict_timecode(req));
        requests_sent++;
        if (req.action == ACT_JAM)
            jams_sent++;
        if (req.action == ACT_ADVANCE)
            advances_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        req_if.valid = 1'b0;
        while (expected_timecodes.size() != 0)
            @(posedge clk);
    endtask

    // block must be idle before the rate register changes
    task automatic set_rate_mode(input logic [2:0] mode, input bit junk_upper);
        logic [APB_DATA_W-1:0] value;
        wait_for_results();
        repeat (4) @(negedge clk);
        value = junk_upper ? {APB_DATA_W'($urandom) & ~APB_DATA_W'(7)} | APB_DATA_W'(mode)
                           : APB_DATA_W'(mode);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = RATE_MODE_ADDR;
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        tc_mode = value[2:0];
        modes_seen[value[2:0]] = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        repeat (2) @(negedge clk);
    endtask

    task automatic test_reset_state();
        modes_seen[tc_mode] = 1'b1;
        send_request(make_request(ACT_IDLE));
        send_request(make_request(ACT_ADVANCE));
    endtask

    task automatic test_jam_extremes();
        tfc_in_t r;
        set_rate_mode(MODE_30, 1'b0);
        send_request(make_jam(0, 0, 0, 0));
        send_request(make_jam(23, 59, 59, 29));
        // non-decimal nibbles at every field maximum
        r = '1;
        r.action = ACT_JAM;
        send_request(r);
    endtask

    task automatic test_count_beyond_day();
        tfc_in_t r;
        set_rate_mode(MODE_24, 1'b0);
        r = '1;
        r.action = ACT_JAM;
        send_request(r);
        send_request(make_request(ACT_ADVANCE));
        send_request(make_request(ACT_ADVANCE));
    endtask

    task automatic test_day_wrap();
        logic [2:0] wrap_modes[3];
        wrap_modes = '{MODE_23_98, MODE_25, MODE_SPARE7};
        foreach (wrap_modes[i])
        begin
            set_rate_mode(wrap_modes[i], 1'b0);
            send_request(make_jam(23, 59, 59, int'(fps_of(wrap_modes[i])) - 1));
            send_request(make_request(ACT_ADVANCE));
        end
    endtask

    task automatic test_drop_frame();
        set_rate_mode(MODE_DROP, 1'b0);
        // plain minute end skips two counts
        send_request(make_jam(0, 0, 59, 28));
        send_request(make_request(ACT_ADVANCE));
        // tenth minute end keeps every count
        send_request(make_jam(0, 9, 59, 28));
        send_request(make_request(ACT_ADVANCE));
        send_request(make_jam(23, 59, 59, 29));
        send_request(make_request(ACT_ADVANCE));
    endtask

    task automatic test_clear_and_idle_action();
        send_request(make_jam(12, 34, 56, 7));
        send_request(make_request(ACT_IDLE));
        send_request(make_request(ACT_CLEAR));
    endtask

    task automatic test_random_traffic();
        logic [2:0] phase_modes[10];
        int         pick;
        int         rate;
        int         hh;
        int         mm;
        int         ss;
        tfc_in_t    r;
        phase_modes = '{MODE_23_98, MODE_24, MODE_25, MODE_29_97, MODE_DROP,
                        MODE_30, MODE_SPARE6, MODE_SPARE7, MODE_DROP, MODE_30};
        foreach (phase_modes[p])
        begin
            set_rate_mode(phase_modes[p], p % 2 == 1);
            idle_on = (p % 3 != 2);
            rate = int'(fps_of(phase_modes[p]));
            repeat (PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    r = tfc_in_t'($urandom);
                else if (pick < 25)
                begin
                    // land a few frames short of a minute or day end
                    hh = ($urandom_range(0, 3) == 0) ? 23 : $urandom_range(0, 23);
                    mm = $urandom_range(0, 1) ? $urandom_range(0, 5) * 10 + 9
                                              : $urandom_range(0, 59);
                    ss = ($urandom_range(0, 3) != 0) ? 59 : $urandom_range(0, 59);
                    r  = make_jam(hh, mm, ss, rate - 1 - $urandom_range(0, 3));
                end
                else if (pick < 30)
                    r = make_request(ACT_CLEAR);
                else if (pick < 33)
                    r = make_request(ACT_IDLE);
                else
                    r = make_request(ACT_ADVANCE);
                send_request(r);
            end
        end
        idle_on = 1'b1;
    endtask

    // result side: random ready stalls, in-order compare
    initial
    begin : result_checker
        int       gap;
        tfc_out_t got;
        tfc_out_t want;
        res_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = idle_on ? $urandom_range(0, 4) : 0;
            @(negedge clk);
            if (gap > 0)
            begin
                res_if.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_if.ready = 1'b1;
            do @(posedge clk); while (!res_if.valid);
            got = res_if.payload;
            results_seen++;
            if (expected_timecodes.size() == 0)
                report_mismatch("result with no request", got.count_now, 0);
            else
            begin
                want = expected_timecodes.pop_front();
                if (got.count_now !== want.count_now)
                    report_mismatch("count_now", got.count_now, want.count_now);
                if (got.hours_out !== want.hours_out)
                    report_mismatch("hours_out", got.hours_out, want.hours_out);
                if (got.minutes_out !== want.minutes_out)
                    report_mismatch("minutes_out", got.minutes_out, want.minutes_out);
                if (got.seconds_out !== want.seconds_out)
                    report_mismatch("seconds_out", got.seconds_out, want.seconds_out);
                if (got.frames_out !== want.frames_out)
                    report_mismatch("frames_out", got.frames_out, want.frames_out);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("[timecode_frame_counter_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        tc_count       = '0;
        tc_mode        = MODE_23_98;
        idle_on        = 1'b1;
        error_count    = 0;
        requests_sent  = 0;
        results_seen   = 0;
        jams_sent      = 0;
        advances_sent  = 0;
        day_wraps      = 0;
        drop_skips     = 0;
        modes_seen     = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_jam_extremes();
        test_count_beyond_day();
        test_day_wrap();
        test_drop_frame();
        test_clear_and_idle_action();
        test_random_traffic();

        wait_for_results();
        repeat (SETTLE_WAIT) @(posedge clk);
        if (expected_timecodes.size() != 0)
            report_mismatch("requests left without result", expected_timecodes.size(), 0);

        $display("covered %0d requests (%0d jams, %0d advances), %0d results, rate modes 0x%02h",
                 requests_sent, jams_sent, advances_sent, results_seen, modes_seen);
        $display("day wraps %0d, drop-frame skips %0d, mismatches %0d",
                 day_wraps, drop_skips, error_count);
        if (error_count == 0)
            $display("[timecode_frame_counter_top] OK");
        else
            $display("[timecode_frame_counter_top] ERROR");
        $finish;
    end

endmodule
